### rtl/rscf_pkg.sv
package rscf_pkg;

  localparam int NumSensors = 36;
  localparam int EdgeW      = NumSensors + 1;
  localparam int IdxW       = 6;
  localparam int MaxRuns    = 3;
  localparam int NumStages  = 6;
  localparam int LaneStages = 4;

  localparam logic [IdxW-1:0] NoneIdx = IdxW'(63);

  typedef struct packed {
    logic                           ovf;
    logic [1:0]                     count;
    logic [MaxRuns-1:0][IdxW-1:0]   run_start;
    logic [MaxRuns-1:0][IdxW-1:0]   run_last;
  } scan_res_t;

  // index of the lowest set bit
  function automatic logic [IdxW-1:0] low_idx(input logic [EdgeW-1:0] x);
    logic [EdgeW-1:0] iso;
    logic [IdxW-1:0]  idx;
    iso = x & (~x + EdgeW'(1));
    idx = '0;
    for (int i = 0; i < EdgeW; i++) begin
      if (iso[i]) begin
        idx = idx | IdxW'(i);
      end
    end
    return idx;
  endfunction

  // index of the highest set bit
  function automatic logic [IdxW-1:0] high_idx(input logic [EdgeW-1:0] x);
    logic [EdgeW-1:0] rev;
    logic [EdgeW-1:0] iso;
    logic [IdxW-1:0]  idx;
    for (int i = 0; i < EdgeW; i++) begin
      rev[i] = x[EdgeW-1-i];
    end
    iso = rev & (~rev + EdgeW'(1));
    idx = '0;
    for (int i = 0; i < EdgeW; i++) begin
      if (iso[i]) begin
        idx = idx | IdxW'(EdgeW - 1 - i);
      end
    end
    return idx;
  endfunction

  // drop the lowest set bit
  function automatic logic [EdgeW-1:0] low_clear(input logic [EdgeW-1:0] x);
    return x & (x - EdgeW'(1));
  endfunction

  // an off sensor with both ring neighbors on turns on
  function automatic logic [NumSensors-1:0] fill_in(input logic [NumSensors-1:0] v);
    logic [NumSensors-1:0] left;
    logic [NumSensors-1:0] right;
    left  = {v[NumSensors-2:0], v[NumSensors-1]};
    right = {v[0], v[NumSensors-1:1]};
    return v | (left & right);
  endfunction

endpackage

### rtl/rscf_lane.sv
module rscf_lane (
  input  logic                                clk_i,
  input  logic [rscf_pkg::LaneStages-1:0]     stage_ld_i,
  input  logic [rscf_pkg::NumSensors-1:0]     vec_i,
  output rscf_pkg::scan_res_t                 res_o
);

  localparam int N = rscf_pkg::NumSensors;
  localparam int W = rscf_pkg::EdgeW;
  localparam int I = rscf_pkg::IdxW;

  logic [W-1:0] rise_d, fall_d;
  logic         wrap_d;

  // stage 1: edges
  logic [W-1:0] rise1_q, fall1_q;
  logic         wrap1_q;

  // stage 2: first run
  logic [W-1:0] rise2_q, fall2_q;
  logic [I-1:0] st0_2_q, en0_2_q;
  logic         has0_2_q;

  // stage 3: second run
  logic [W-1:0] rise3_q, fall3_q;
  logic [I-1:0] st0_3_q, en0_3_q, st1_3_q, en1_3_q;
  logic         has0_3_q, has1_3_q;

  // stage 4: third run and overflow
  logic [I-1:0] st0_4_q, en0_4_q, st1_4_q, en1_4_q, st2_4_q, en2_4_q;
  logic         has0_4_q, has1_4_q, has2_4_q, ovf_4_q;

  always_comb begin
    rise_d    = '0;
    fall_d    = '0;
    rise_d[0] = vec_i[0];
    for (int i = 1; i < N; i++) begin
      rise_d[i] = vec_i[i] & ~vec_i[i-1];
      fall_d[i] = ~vec_i[i] & vec_i[i-1];
    end
    // open run at the seam closes at the last sensor unless it wraps
    fall_d[N] = vec_i[N-1] & ~vec_i[0];
    wrap_d    = vec_i[N-1] & vec_i[0];
  end

  always_ff @(posedge clk_i) begin
    if (stage_ld_i[0]) begin
      rise1_q <= rise_d;
      fall1_q <= fall_d;
      wrap1_q <= wrap_d;
    end
    if (stage_ld_i[1]) begin
      rise2_q  <= rscf_pkg::low_clear(rise1_q);
      fall2_q  <= rscf_pkg::low_clear(fall1_q);
      st0_2_q  <= wrap1_q ? rscf_pkg::high_idx(rise1_q) : rscf_pkg::low_idx(rise1_q);
      en0_2_q  <= rscf_pkg::low_idx(fall1_q) - I'(1);
      has0_2_q <= |fall1_q;
    end
    if (stage_ld_i[2]) begin
      rise3_q  <= rscf_pkg::low_clear(rise2_q);
      fall3_q  <= rscf_pkg::low_clear(fall2_q);
      st0_3_q  <= st0_2_q;
      en0_3_q  <= en0_2_q;
      has0_3_q <= has0_2_q;
      st1_3_q  <= rscf_pkg::low_idx(rise2_q);
      en1_3_q  <= rscf_pkg::low_idx(fall2_q) - I'(1);
      has1_3_q <= |fall2_q;
    end
    if (stage_ld_i[3]) begin
      st0_4_q  <= st0_3_q;
      en0_4_q  <= en0_3_q;
      has0_4_q <= has0_3_q;
      st1_4_q  <= st1_3_q;
      en1_4_q  <= en1_3_q;
      has1_4_q <= has1_3_q;
      st2_4_q  <= rscf_pkg::low_idx(rise3_q);
      en2_4_q  <= rscf_pkg::low_idx(fall3_q) - I'(1);
      has2_4_q <= |fall3_q;
      ovf_4_q  <= |rscf_pkg::low_clear(fall3_q);
    end
  end

  always_comb begin
    res_o.ovf          = ovf_4_q;
    res_o.count        = 2'(has0_4_q) + 2'(has1_4_q) + 2'(has2_4_q);
    res_o.run_start[0] = has0_4_q ? st0_4_q : rscf_pkg::NoneIdx;
    res_o.run_last[0]  = has0_4_q ? en0_4_q : rscf_pkg::NoneIdx;
    res_o.run_start[1] = has1_4_q ? st1_4_q : rscf_pkg::NoneIdx;
    res_o.run_last[1]  = has1_4_q ? en1_4_q : rscf_pkg::NoneIdx;
    res_o.run_start[2] = has2_4_q ? st2_4_q : rscf_pkg::NoneIdx;
    res_o.run_last[2]  = has2_4_q ? en2_4_q : rscf_pkg::NoneIdx;
  end

endmodule

### rtl/ring_sensor_cluster_finder.sv
// Ring sensor cluster finder.
// Input channel: in_valid_i / in_stall_o carry one sensor_bits_i request, one bit per
// ring sensor; a request is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result per request: cluster count,
// start and end index of up to three clusters (63 for none) and the fill-in flag.
// Path: from the accepting edge to out_valid_o a request passes through six register stages
// (input, edge detect, three run-extraction stages, output register).
// Throughput: one request per cycle while out_stall_i is low. The plain and the filled-in
// vector are scanned in two parallel lanes, so the retry needs no second pass.
// Reset clears all stage valid bits; the pipeline is empty and no result is shown.
// When out_stall_i is high the output register holds its result; earlier stages keep
// filling bubbles and in_stall_o rises only once every stage holds a request.
module ring_sensor_cluster_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [35:0] sensor_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  cluster_count_o,
  output logic [5:0]  first_start_o,
  output logic [5:0]  first_end_o,
  output logic [5:0]  second_start_o,
  output logic [5:0]  second_end_o,
  output logic [5:0]  third_start_o,
  output logic [5:0]  third_end_o,
  output logic        used_fill_in_o
);

  localparam int S = rscf_pkg::NumStages;
  localparam int N = rscf_pkg::NumSensors;

  logic [S-1:0] vld_q, vld_d, rdy;
  logic [N-1:0] vec_q;
  rscf_pkg::scan_res_t raw_res, fill_res, out_d, out_q;
  logic used_d, used_q;

  always_comb begin
    rdy[S-1] = !vld_q[S-1] || !out_stall_i;
    for (int k = S - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < S; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      vec_q <= sensor_bits_i[N-1:0];
    end
    if (rdy[S-1]) begin
      out_q  <= out_d;
      used_q <= used_d;
    end
  end

  rscf_lane u_lane_raw (
    .clk_i      (clk_i),
    .stage_ld_i (rdy[S-2:1]),
    .vec_i      (vec_q),
    .res_o      (raw_res)
  );

  rscf_lane u_lane_fill (
    .clk_i      (clk_i),
    .stage_ld_i (rdy[S-2:1]),
    .vec_i      (rscf_pkg::fill_in(vec_q)),
    .res_o      (fill_res)
  );

  always_comb begin
    used_d = raw_res.ovf;
    out_d  = raw_res;
    if (raw_res.ovf) begin
      out_d = fill_res;
      if (fill_res.ovf) begin
        out_d.count     = '0;
        out_d.run_start = {rscf_pkg::MaxRuns{rscf_pkg::NoneIdx}};
        out_d.run_last  = {rscf_pkg::MaxRuns{rscf_pkg::NoneIdx}};
      end
    end
  end

  assign in_stall_o      = !rdy[0];
  assign out_valid_o     = vld_q[S-1];
  assign cluster_count_o = out_q.count;
  assign first_start_o   = out_q.run_start[0];
  assign first_end_o     = out_q.run_last[0];
  assign second_start_o  = out_q.run_start[1];
  assign second_end_o    = out_q.run_last[1];
  assign third_start_o   = out_q.run_start[2];
  assign third_end_o     = out_q.run_last[2];
  assign used_fill_in_o  = out_q.ovf || used_q;

  a_empty_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cluster_count_o == 2'd0 |->
      first_start_o == rscf_pkg::NoneIdx && first_end_o == rscf_pkg::NoneIdx)
    else $error("zero clusters with an index set");

  a_third_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cluster_count_o != 2'd3 |->
      third_start_o == rscf_pkg::NoneIdx && third_end_o == rscf_pkg::NoneIdx)
    else $error("third cluster reported beyond count");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted request not captured");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S-2] && !rdy[S-2] |=> vld_q[S-2])
    else $error("stalled request lost in last lane stage");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              NumSensors = rscf_pkg::NumSensors;
  localparam int              IdxW       = rscf_pkg::IdxW;
  localparam int              MaxRuns    = rscf_pkg::MaxRuns;
  localparam logic [IdxW-1:0] NoneIdx    = rscf_pkg::NoneIdx;

  localparam int RandomRequests = 930;
  localparam int WatchdogLimit  = 2000;
  localparam int SettleCycles   = 20;
  localparam int HoldCycles     = 60;
  localparam int FirstHoldAt    = 300;
  localparam int SecondHoldAt   = 700;

  typedef struct packed {
    logic [1:0]      cluster_count;
    logic [IdxW-1:0] first_start;
    logic [IdxW-1:0] first_end;
    logic [IdxW-1:0] second_start;
    logic [IdxW-1:0] second_end;
    logic [IdxW-1:0] third_start;
    logic [IdxW-1:0] third_end;
    logic            used_fill_in;
  } cluster_report_t;

  typedef struct packed {
    logic            too_many;
    logic [2:0]      runs;
    logic [3:0][IdxW-1:0] starts;
    logic [3:0][IdxW-1:0] ends;
  } run_scan_t;

  typedef struct packed {
    logic                  drain;
    logic [NumSensors-1:0] bits;
    logic [7:0]            gap;
  } sensor_request_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [NumSensors-1:0] sensor_bits_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            cluster_count_o;
  logic [IdxW-1:0]       first_start_o;
  logic [IdxW-1:0]       first_end_o;
  logic [IdxW-1:0]       second_start_o;
  logic [IdxW-1:0]       second_end_o;
  logic [IdxW-1:0]       third_start_o;
  logic [IdxW-1:0]       third_end_o;
  logic                  used_fill_in_o;

  sensor_request_t requests [$];
  cluster_report_t reports_due [$];
  sensor_request_t next_req;
  cluster_report_t want_rep;
  cluster_report_t got_rep;

  logic        in_taken = 1'b0;
  logic        waiting_drain = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int          holds_done = 0;
  logic        recv_busy = 1'b1;
  int          accepted_in = 0;
  int          results_checked = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  int          fill_retries = 0;
  int          unresolved = 0;
  int          wrapped = 0;
  int          input_stalls = 0;
  int          count_hist [4];

  ring_sensor_cluster_finder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sensor_bits_i   (sensor_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cluster_count_o (cluster_count_o),
    .first_start_o   (first_start_o),
    .first_end_o     (first_end_o),
    .second_start_o  (second_start_o),
    .second_end_o    (second_end_o),
    .third_start_o   (third_start_o),
    .third_end_o     (third_end_o),
    .used_fill_in_o  (used_fill_in_o)
  );

  // scan from index 0 upward, flagging too_many once a fourth run closes
  function automatic run_scan_t find_runs(input logic [NumSensors-1:0] v);
    run_scan_t r;
    logic      prev;
    r.too_many = 1'b0;
    r.runs     = '0;
    r.starts   = {4{NoneIdx}};
    r.ends     = {4{NoneIdx}};
    prev       = 1'b0;
    for (int i = 0; i < NumSensors; i++) begin
      if (!r.too_many) begin
        if (v[i] && !prev) begin
          r.starts[r.runs] = IdxW'(i);
        end
        if (!v[i] && prev) begin
          r.ends[r.runs] = IdxW'(i - 1);
          r.runs = r.runs + 3'd1;
          if (r.runs > 3'(MaxRuns)) begin
            r.too_many = 1'b1;
          end
        end
        prev = v[i];
      end
    end
    if (!r.too_many && prev) begin
      // open run at the seam joins the first run when that one starts at sensor 0
      if (r.starts[0] == '0) begin
        r.starts[0] = r.starts[r.runs];
      end else begin
        r.ends[r.runs] = IdxW'(NumSensors - 1);
        r.runs = r.runs + 3'd1;
        if (r.runs > 3'(MaxRuns)) begin
          r.too_many = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [NumSensors-1:0] fill_gaps(input logic [NumSensors-1:0] v);
    logic [NumSensors-1:0] f;
    f = v;
    for (int i = 0; i < NumSensors; i++) begin
      if (v[(i + 1) % NumSensors] && v[(i + NumSensors - 1) % NumSensors]) begin
        f[i] = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic cluster_report_t predict_clusters(input logic [NumSensors-1:0] v);
    run_scan_t       sc;
    cluster_report_t rep;
    rep.used_fill_in = 1'b0;
    sc = find_runs(v);
    if (sc.too_many) begin
      rep.used_fill_in = 1'b1;
      sc = find_runs(fill_gaps(v));
    end
    if (sc.too_many) begin
      sc.runs = '0;
    end
    for (int k = 0; k < 4; k++) begin
      if (k >= sc.runs) begin
        sc.starts[k] = NoneIdx;
        sc.ends[k]   = NoneIdx;
      end
    end
    rep.cluster_count = sc.runs[1:0];
    rep.first_start   = sc.starts[0];
    rep.first_end     = sc.ends[0];
    rep.second_start  = sc.starts[1];
    rep.second_end    = sc.ends[1];
    rep.third_start   = sc.starts[2];
    rep.third_end     = sc.ends[2];
    return rep;
  endfunction

  // mostly short, sometimes medium, rarely long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [NumSensors-1:0] random_sensor_bits();
    logic [NumSensors-1:0] v;
    int unsigned           kind;
    int unsigned           count;
    int unsigned           first;
    int unsigned           len;
    int unsigned           pct;
    kind = $urandom_range(0, 9);
    v = '0;
    case (kind)
      0, 1: begin
        v = NumSensors'({$urandom, $urandom});
      end
      2, 3, 4, 5: begin
        // a few runs, possibly touching or wrapping the seam
        count = $urandom_range(1, 5);
        for (int j = 0; j < count; j++) begin
          first = $urandom_range(0, NumSensors - 1);
          len   = $urandom_range(1, 8);
          for (int m = 0; m < len; m++) begin
            v[(first + m) % NumSensors] = 1'b1;
          end
        end
      end
      6, 7: begin
        pct = ($urandom_range(0, 1) == 0) ? $urandom_range(5, 25) : $urandom_range(70, 95);
        for (int i = 0; i < NumSensors; i++) begin
          v[i] = ($urandom_range(0, 99) < pct);
        end
      end
      8: begin
        // random holes, which the fill-in closes where they are isolated
        v = '1;
        count = $urandom_range(1, 6);
        for (int j = 0; j < count; j++) begin
          v[$urandom_range(0, NumSensors - 1)] = 1'b0;
        end
      end
      default: begin
        count = $urandom_range(0, 4);
        for (int j = 0; j < count; j++) begin
          v[$urandom_range(0, NumSensors - 1)] = 1'b1;
        end
      end
    endcase
    return v;
  endfunction

  task automatic queue_request(input logic [NumSensors-1:0] bits, input bit back_to_back);
    sensor_request_t req;
    req.drain = 1'b0;
    req.bits  = bits;
    req.gap   = (back_to_back || $urandom_range(0, 1) == 0) ? 8'd0 : 8'(idle_length());
    requests.push_back(req);
  endtask

  task automatic queue_pause();
    sensor_request_t req;
    req = '0;
    req.drain = 1'b1;
    requests.push_back(req);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (waiting_drain) begin
        if (reports_due.size() == 0) begin
          waiting_drain <= 1'b0;
        end
        in_valid_i <= 1'b0;
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (requests.size() != 0) begin
        next_req = requests.pop_front();
        if (next_req.drain) begin
          waiting_drain <= 1'b1;
          in_valid_i    <= 1'b0;
        end else begin
          in_valid_i    <= 1'b1;
          sensor_bits_i <= next_req.bits;
          gap_left      <= next_req.gap;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (holds_done < 2 &&
                   accepted_in >= ((holds_done == 0) ? FirstHoldAt : SecondHoldAt)) begin
        // long hold-off so the pipeline fills and stalls its input
        out_stall_i <= 1'b1;
        hold_left   <= HoldCycles - 1;
        holds_done  <= holds_done + 1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (recv_busy && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= idle_length() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if ($urandom_range(0, 47) == 0) begin
        recv_busy <= !recv_busy;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && in_stall_o) begin
        input_stalls++;
      end
      if (in_valid_i && !in_stall_o) begin
        reports_due.push_back(predict_clusters(sensor_bits_i));
        accepted_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got_rep = {cluster_count_o, first_start_o, first_end_o, second_start_o, second_end_o,
                   third_start_o, third_end_o, used_fill_in_o};
        if (reports_due.size() == 0) begin
          $display("%0t ns: result with no request pending, actual count %0d",
                   $time, cluster_count_o);
          errors++;
        end else begin
          want_rep = reports_due.pop_front();
          check_field("cluster_count", want_rep.cluster_count, got_rep.cluster_count);
          check_field("first_start", want_rep.first_start, got_rep.first_start);
          check_field("first_end", want_rep.first_end, got_rep.first_end);
          check_field("second_start", want_rep.second_start, got_rep.second_start);
          check_field("second_end", want_rep.second_end, got_rep.second_end);
          check_field("third_start", want_rep.third_start, got_rep.third_start);
          check_field("third_end", want_rep.third_end, got_rep.third_end);
          check_field("used_fill_in", want_rep.used_fill_in, got_rep.used_fill_in);
          results_checked++;
          count_hist[want_rep.cluster_count]++;
          if (want_rep.used_fill_in) begin
            fill_retries++;
            if (want_rep.cluster_count == 2'd0) begin
              unresolved++;
            end
          end
          if (want_rep.cluster_count != 2'd0 && want_rep.first_start > want_rep.first_end) begin
            wrapped++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned calm_left;
    bit          busy;
    calm_left = 0;
    for (int k = 0; k < 4; k++) begin
      count_hist[k] = 0;
    end

    queue_request(36'h000000000, 1'b0);
    queue_request(36'hFFFFFFFFF, 1'b0);
    queue_request(36'h000000001, 1'b0);
    queue_request(36'h800000000, 1'b0);
    queue_request(36'hE00000007, 1'b0);
    queue_request(36'h00F00F00F, 1'b1);
    queue_request(36'h000007777, 1'b1);
    queue_request(36'h000001111, 1'b0);
    queue_request(36'h000011111, 1'b1);
    queue_request(36'h555555555, 1'b0);
    queue_request(36'hAAAAAAAAA, 1'b1);
    queue_request(36'hC000030C3, 1'b0);
    queue_request(36'h800000444, 1'b1);
    queue_request(36'h400100405, 1'b0);
    queue_request(36'h800000002, 1'b1);
    queue_request(36'h7FFFFFFFF, 1'b0);
    queue_request(36'hFFFFFFFFE, 1'b1);
    queue_request(36'hFFFFFFFF7, 1'b0);
    queue_request(36'h000000003, 1'b1);
    queue_request(36'h0C0000000, 1'b0);
    queue_pause();

    for (int i = 0; i < RandomRequests; i++) begin
      if (calm_left != 0) begin
        calm_left--;
      end else if ($urandom_range(0, 29) == 0) begin
        calm_left = $urandom_range(10, 40);
      end
      if (i == 450 || i == 820) begin
        queue_pause();
      end
      busy = (calm_left != 0) || (i >= 270 && i < 360) || (i >= 660 && i < 750);
      queue_request(random_sensor_bits(), busy);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((requests.size() != 0 || in_valid_i || waiting_drain || reports_due.size() != 0) &&
           idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
    end

    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, reports_due.size());
      $display("ring_sensor_cluster_finder verification failed");
    end else begin
      repeat (SettleCycles) @(posedge clk_i);
      $display("%0d scans checked: %0d retried with fill-in (%0d unresolved), %0d across seam",
               results_checked, fill_retries, unresolved, wrapped);
      $display("cluster counts 0/1/2/3: %0d/%0d/%0d/%0d, %0d input stall cycles",
               count_hist[0], count_hist[1], count_hist[2], count_hist[3], input_stalls);
      if (errors == 0) begin
        $display("ring_sensor_cluster_finder verification clean");
      end else begin
        $display("ring_sensor_cluster_finder verification failed");
      end
    end
    $finish;
  end

endmodule
